[hw/rtl/pbacc_pkg.sv]
// Package for the pulsar phase bin accumulator.
// Holds sizing constants, field widths and configuration register indexes.
// No dependencies.
package pbacc_pkg;

    localparam int NUM_BINS      = 16;
    localparam int NUM_BASELINES = 16;
    localparam int FFT_CHANNELS  = 256;

    localparam int ROW_LEN    = FFT_CHANNELS + 1;
    localparam int ACC_DEPTH  = NUM_BINS * NUM_BASELINES * ROW_LEN;
    localparam int ACC_ADDR_W = $clog2(ACC_DEPTH);

    localparam int PHASE_W = 16;
    localparam int GEND_W  = 17;
    localparam int BINS_W  = 4;
    localparam int SCALE_W = 24;
    localparam int SAMP_W  = 16;
    localparam int BIN_W   = 4;
    localparam int BL_W    = 4;
    localparam int CH_W    = 9;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 2 * SAMP_W + 1;
    localparam int DIFF_W  = PHASE_W + 1;
    localparam int SPROD_W = DIFF_W + SCALE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_BEGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_BINS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE  = 2'd3;

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

endpackage

[hw/rtl/pulsar_phase_bin_accumulator.sv]
// Top level of the pulsar phase bin accumulator: phase gating, binning,
// cross product and read-modify-write of the accumulator memories.
// Depends on pbacc_pkg.
//
//  channel   signals                              direction
//  in        in_valid / in_stall + input fields   word into the block
//  out       out_valid / out_stall + result       word out of the block
//  cfg       cfg_we, cfg_index, cfg_data          register writes
//
// Each word passes through accept, products, bin scale, memory read,
// update and write-back; only one word is in flight at a time.
// After reset a clearing pass zeroes all 65792 entries, one per cycle,
// with in_stall held high; cfg writes are taken during it.
// The result sits in an output register; a stalled output holds the final
// update step, and the next word is not accepted until that step ends.
module pulsar_phase_bin_accumulator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pbacc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbacc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [pbacc_pkg::BL_W-1:0]        baseline,
    input  logic [pbacc_pkg::CH_W-1:0]        channel,
    input  logic [pbacc_pkg::PHASE_W-1:0]     fft_phase,
    input  logic [pbacc_pkg::PHASE_W-1:0]     channel_offset,
    input  logic signed [pbacc_pkg::SAMP_W-1:0] a_re,
    input  logic signed [pbacc_pkg::SAMP_W-1:0] a_im,
    input  logic signed [pbacc_pkg::SAMP_W-1:0] b_re,
    input  logic signed [pbacc_pkg::SAMP_W-1:0] b_im,
    input  logic [pbacc_pkg::BIN_W-1:0]       read_bin,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pbacc_pkg::BIN_W-1:0]       bin_index,
    output logic signed [pbacc_pkg::ACC_W-1:0] sum_re,
    output logic signed [pbacc_pkg::ACC_W-1:0] sum_im
);
    import pbacc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_ADDR,
        S_UPD
    } state_t;

    localparam logic [8:0] BIN_MAX = 9'(NUM_BINS - 1);

    state_t state_reg;
    logic [ACC_ADDR_W-1:0] clr_cnt_reg;
    logic out_valid_reg;

    logic [PHASE_W-1:0] gate_begin_reg;
    logic [GEND_W-1:0]  gate_end_reg;
    logic [BINS_W-1:0]  on_bins_reg;
    logic [SCALE_W-1:0] bin_scale_reg;

    // input word
    logic               mode_reg;
    logic [BL_W-1:0]    bl_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [PHASE_W-1:0] fft_phase_reg;
    logic [PHASE_W-1:0] ch_off_reg;
    logic signed [SAMP_W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic [BIN_W-1:0]   read_bin_reg;

    // datapath
    logic signed [2*SAMP_W-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic [DIFF_W-1:0]  d_reg;
    logic               in_gate_reg;
    logic [SPROD_W-1:0] scaled_reg;
    logic               on_gate_reg;
    logic signed [PROD_W-1:0] pr_reg, pi_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [ACC_ADDR_W-1:0] addr_reg;
    logic               addr_ok_reg;
    logic [ACC_W-1:0]   rd_re_reg, rd_im_reg;

    logic [BIN_W-1:0]   bin_index_reg;
    logic [ACC_W-1:0]   sum_re_reg, sum_im_reg;

    // memories
    logic [ACC_W-1:0] acc_re_mem [ACC_DEPTH];
    logic [ACC_W-1:0] acc_im_mem [ACC_DEPTH];

    logic [PHASE_W-1:0] phase;
    logic               win_lo, win_hi;
    logic [DIFF_W-1:0]  d_lo, d_hi;
    logic [9:0]         b_raw;
    logic [BIN_W-1:0]   cap, bin_next;
    logic [ACC_ADDR_W-1:0] addr_next;
    logic               addr_ok_next;
    logic               upd_go;
    logic               mem_we;
    logic [ACC_ADDR_W-1:0] mem_waddr;
    logic [ACC_W-1:0]   mem_wre, mem_wim;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign bin_index = bin_index_reg;
    assign sum_re    = sum_re_reg;
    assign sum_im    = sum_im_reg;

    // phase gate
    always_comb
    begin
        phase  = fft_phase_reg - ch_off_reg;
        win_lo = (phase >= gate_begin_reg) && ({1'b0, phase} < gate_end_reg);
        win_hi = (phase < gate_begin_reg) && ({1'b1, phase} < gate_end_reg);
        d_lo   = {1'b0, phase} - {1'b0, gate_begin_reg};
        d_hi   = {1'b1, phase} - {1'b0, gate_begin_reg};
    end

    // bin clamp and address
    always_comb
    begin
        b_raw = {1'b0, scaled_reg[SPROD_W-1:32]} + 10'd1;
        if ({5'd0, on_bins_reg} > BIN_MAX)
            cap = BIN_MAX[BIN_W-1:0];
        else
            cap = on_bins_reg;
        if (mode_reg == MODE_READ)
            bin_next = read_bin_reg;
        else if (!on_gate_reg)
            bin_next = '0;
        else if (b_raw > {6'd0, cap})
            bin_next = cap;
        else
            bin_next = b_raw[BIN_W-1:0];
        addr_ok_next = (32'(bin_next) < NUM_BINS) && (32'(bl_reg) < NUM_BASELINES)
                       && (32'(ch_reg) <= FFT_CHANNELS);
        addr_next = (ACC_ADDR_W'(bin_next) * ACC_ADDR_W'(NUM_BASELINES)
                     + ACC_ADDR_W'(bl_reg)) * ACC_ADDR_W'(ROW_LEN)
                    + ACC_ADDR_W'(ch_reg);
        if (!addr_ok_next)
            addr_next = '0;
    end

    assign upd_go = (state_reg == S_UPD) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wre   = '0;
        mem_wim   = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (upd_go && addr_ok_reg)
        begin
            mem_we = 1'b1;
            if (mode_reg == MODE_ACCUM)
            begin
                mem_wre = rd_re_reg + ACC_W'(pr_reg);
                mem_wim = rd_im_reg + ACC_W'(pi_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            acc_re_mem[mem_waddr] <= mem_wre;
            acc_im_mem[mem_waddr] <= mem_wim;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADDR)
        begin
            rd_re_reg <= acc_re_mem[addr_next];
            rd_im_reg <= acc_im_mem[addr_next];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_begin_reg <= '0;
            gate_end_reg   <= GEND_W'(65536);
            on_bins_reg    <= BINS_W'(1);
            bin_scale_reg  <= SCALE_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GATE_BEGIN: gate_begin_reg <= cfg_data[PHASE_W-1:0];
                CFG_GATE_END:   gate_end_reg   <= cfg_data[GEND_W-1:0];
                CFG_ON_BINS:    on_bins_reg    <= cfg_data[BINS_W-1:0];
                CFG_BIN_SCALE:  bin_scale_reg  <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg      <= mode;
            bl_reg        <= baseline;
            ch_reg        <= channel;
            fft_phase_reg <= fft_phase;
            ch_off_reg    <= channel_offset;
            ar_reg        <= a_re;
            ai_reg        <= a_im;
            br_reg        <= b_re;
            bi_reg        <= b_im;
            read_bin_reg  <= read_bin;
        end
        if (state_reg == S_MUL)
        begin
            p_rr_reg    <= ar_reg * br_reg;
            p_ii_reg    <= ai_reg * bi_reg;
            p_ir_reg    <= ai_reg * br_reg;
            p_ri_reg    <= ar_reg * bi_reg;
            in_gate_reg <= win_lo || win_hi;
            d_reg       <= win_lo ? d_lo : d_hi;
        end
        if (state_reg == S_SCALE)
        begin
            scaled_reg  <= SPROD_W'(d_reg) * SPROD_W'(bin_scale_reg);
            on_gate_reg <= in_gate_reg;
            pr_reg      <= PROD_W'(p_rr_reg) + PROD_W'(p_ii_reg);
            pi_reg      <= PROD_W'(p_ir_reg) - PROD_W'(p_ri_reg);
        end
        if (state_reg == S_ADDR)
        begin
            bin_reg     <= bin_next;
            addr_reg    <= addr_next;
            addr_ok_reg <= addr_ok_next;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            bin_index_reg <= '0;
            sum_re_reg    <= '0;
            sum_im_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ACC_ADDR_W'(ACC_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_MUL;
                end
                S_MUL:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_ADDR;
                S_ADDR:  state_reg <= S_UPD;
                S_UPD:
                begin
                    if (upd_go)
                    begin
                        out_valid_reg <= 1'b1;
                        bin_index_reg <= bin_reg;
                        if (mode_reg == MODE_READ && addr_ok_reg)
                        begin
                            sum_re_reg <= rd_re_reg;
                            sum_im_reg <= rd_im_reg;
                        end
                        else
                        begin
                            sum_re_reg <= '0;
                            sum_im_reg <= '0;
                        end
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MUL))
        else $error("accepted word did not start processing");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_UPD))
        else $error("accumulator written outside clear or update");

    a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_UPD))
        else $error("result raised without an update step");

    a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && out_valid_reg && out_stall) |=> (state_reg == S_UPD))
        else $error("update left while output register full");

endmodule
